>>> rtl/core/lisg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lisg_pkg;

    // item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // compare mode bits, lowest set bit wins
    localparam logic [4:0] MODE_LT = 5'h01;
    localparam logic [4:0] MODE_LE = 5'h02;
    localparam logic [4:0] MODE_GT = 5'h04;
    localparam logic [4:0] MODE_GE = 5'h08;
    localparam logic [4:0] MODE_NE = 5'h10;

    localparam logic [4:0] CONT_COND_RESET = MODE_LT;

    typedef struct packed {
        logic               kind;
        logic signed [63:0] start_value;
        logic signed [63:0] step_value;
        logic signed [63:0] bound_value;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] index;
        logic               cont;
    } t_out_item;

    function automatic logic cond_holds(
        input logic [4:0]         mode,
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic res;
        begin
            if ((mode & MODE_LT) != 5'd0) begin
                res = (a < b);
            end else if ((mode & MODE_LE) != 5'd0) begin
                res = (a <= b);
            end else if ((mode & MODE_GT) != 5'd0) begin
                res = (a > b);
            end else if ((mode & MODE_GE) != 5'd0) begin
                res = (a >= b);
            end else if ((mode & MODE_NE) != 5'd0) begin
                res = (a != b);
            end else begin
                res = 1'b0;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/loop_index_stream_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Loop index stream generator.
// Input channel (i_in_valid / o_in_stall / i_in_data): a start beat loads
// start, step and bound and emits the first index; each advance beat emits
// the next index with its continue flag. The advance after a beat whose flag
// was 0 emits nothing and returns the block to idle. Starts while running and
// advances while idle are dropped without a result.
// Output channel (o_out_valid / i_out_stall / o_out_data): index and cont.
// Config: i_cfg_we / i_cfg_wdata write the 5-bit compare mode (lt, le, gt,
// ge, ne; lowest set bit wins, none set gives cont 0). Write only when idle.
// An accepted beat's result is registered in the output (or skid) register.
// Throughput: one beat per cycle while o_in_stall is low. The index add and
// signed compare are combinational, from state registers to output register.
// A receiver stall is absorbed by a one-beat skid register; o_in_stall rises
// only once that is full, and drops as soon as the output beat is taken.
// Reset (synchronous, active low) clears the phase, the buffers and sets the
// compare mode to lt.

module loop_index_stream_generator_unit
    import lisg_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data
);

    logic      in_accept;
    logic      res_valid;
    t_out_item res;
    logic      buf_full;

    assign in_accept  = i_in_valid && !buf_full;
    assign o_in_stall = buf_full;

    lisg_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lisg_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // skid full means the output register holds a beat too
    a_skid_implies_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid beat held with empty output register");

    // a full skid cannot drain while the receiver stalls
    a_skid_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall && i_out_stall) |=> o_in_stall)
        else $error("skid beat lost under stall");

    // a beat taken while the skid is empty leaves the output register valid
    a_result_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !o_in_stall) |=> o_out_valid)
        else $error("result beat dropped");

endmodule

`default_nettype wire

>>> rtl/core/lisg_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module lisg_seq
    import lisg_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [4:0] i_cfg_wdata,
    input  wire logic      i_accept,
    input  wire t_in_item  i_item,
    output logic           o_res_valid,
    output t_out_item      o_res
);

    logic [4:0]         r_cont_cond;
    logic               r_running;
    logic               r_term;
    logic signed [63:0] r_next;
    logic signed [63:0] r_step;
    logic signed [63:0] r_bound;

    logic               n_running;
    logic               n_term;
    logic signed [63:0] n_next;
    logic signed [63:0] n_step;
    logic signed [63:0] n_bound;

    logic               is_start;
    logic signed [63:0] cur_idx;
    logic signed [63:0] cur_step;
    logic signed [63:0] cur_bound;
    logic signed [63:0] sum;
    logic               cond;

    assign is_start  = (i_item.kind == KIND_START);
    assign cur_idx   = is_start ? i_item.start_value : r_next;
    assign cur_step  = is_start ? i_item.step_value  : r_step;
    assign cur_bound = is_start ? i_item.bound_value : r_bound;
    assign sum       = cur_idx + cur_step;
    assign cond      = cond_holds(r_cont_cond, cur_idx, cur_bound);

    always_comb begin
        n_running   = r_running;
        n_term      = r_term;
        n_next      = r_next;
        n_step      = r_step;
        n_bound     = r_bound;
        o_res_valid = 1'b0;
        o_res.index = cur_idx;
        o_res.cont  = cond;
        if (i_accept) begin
            if (is_start) begin
                if (!r_running) begin
                    n_step      = i_item.step_value;
                    n_bound     = i_item.bound_value;
                    n_next      = sum;
                    n_running   = 1'b1;
                    n_term      = !cond;
                    o_res_valid = 1'b1;
                end
            end else if (r_running) begin
                if (r_term) begin
                    // last index already taken: back to idle, nothing out
                    n_running = 1'b0;
                    n_term    = 1'b0;
                end else begin
                    n_term      = !cond;
                    o_res_valid = 1'b1;
                    if (cond) begin
                        n_next = sum;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cont_cond <= CONT_COND_RESET;
            r_running   <= 1'b0;
            r_term      <= 1'b0;
            r_next      <= '0;
            r_step      <= '0;
            r_bound     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cont_cond <= i_cfg_wdata;
            end
            r_running <= n_running;
            r_term    <= n_term;
            r_next    <= n_next;
            r_step    <= n_step;
            r_bound   <= n_bound;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lisg_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module lisg_out_buf
    import lisg_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_res_valid,
    input  wire t_out_item i_res,
    output logic           o_full,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out;
    t_out_item r_skid;
    logic      out_take;

    assign out_take    = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (i_res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

endmodule

`default_nettype wire

>>> verif/loop_index_stream_generator_unit_tb.sv
`timescale 1ns / 1ps

module loop_index_stream_generator_unit_tb;
    import lisg_pkg::*;

    localparam logic signed [63:0] IDX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] IDX_MIN = 64'sh8000_0000_0000_0000;
    localparam int MAX_SEQ_LEN    = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTED    = 200;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    logic       in_valid;
    logic       in_stall;
    t_in_item   in_data;
    logic       out_valid;
    logic       out_stall;
    t_out_item  out_data;

    // predicted generator state
    logic [4:0]         seq_mode = CONT_COND_RESET;
    bit                 seq_running;
    bit                 seq_last_sent;
    logic signed [63:0] seq_next;
    logic signed [63:0] seq_step;
    logic signed [63:0] seq_bound;

    t_out_item exp_indices[$];

    int snd_idle_pct;
    int rcv_stall_pct;
    int n_errors;
    int n_beats;
    int n_dropped;
    int n_results;
    int n_mode_writes;
    int idle_cycles;
    bit moved;

    loop_index_stream_generator_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item mk_item(input logic k, input logic [63:0] s,
                                         input logic [63:0] st, input logic [63:0] b);
        t_in_item it;
        it.kind        = k;
        it.start_value = s;
        it.step_value  = st;
        it.bound_value = b;
        return it;
    endfunction

    // lowest set mode bit picks the compare
    function automatic bit cmp_holds(input logic [4:0] mode, input logic signed [63:0] a,
                                     input logic signed [63:0] b);
        logic [4:0] pick;
        pick = mode & (~mode + 5'd1);
        case (pick)
            MODE_LT: return a < b;
            MODE_LE: return a <= b;
            MODE_GT: return a > b;
            MODE_GE: return a >= b;
            MODE_NE: return a != b;
            default: return 1'b0;
        endcase
    endfunction

    // number of results up to and including the last one, 0 if too long
    function automatic int seq_len(input logic [4:0] mode, input logic signed [63:0] s,
                                   input logic signed [63:0] st, input logic signed [63:0] b);
        logic signed [63:0] idx;
        idx = s;
        for (int k = 1; k <= MAX_SEQ_LEN; k++) begin
            if (!cmp_holds(mode, idx, b))
                return k;
            idx = idx + st;
        end
        return 0;
    endfunction

    task automatic report_mismatch(input string what);
        if (n_errors < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, what);
        n_errors++;
    endtask

    task automatic predict_index_beat(input t_in_item it);
        logic signed [63:0] idx;
        bit c;
        if (it.kind == KIND_START) begin
            if (seq_running) begin
                n_dropped++;
                return;
            end
            idx       = it.start_value;
            seq_step  = it.step_value;
            seq_bound = it.bound_value;
            c = cmp_holds(seq_mode, idx, seq_bound);
            seq_next      = idx + seq_step;
            seq_running   = 1'b1;
            seq_last_sent = !c;
        end else begin
            if (!seq_running) begin
                n_dropped++;
                return;
            end
            if (seq_last_sent) begin
                // consumer took the final index: back to idle, no beat out
                seq_running   = 1'b0;
                seq_last_sent = 1'b0;
                return;
            end
            idx = seq_next;
            c = cmp_holds(seq_mode, idx, seq_bound);
            seq_last_sent = !c;
            if (c)
                seq_next = idx + seq_step;
        end
        exp_indices.push_back(t_out_item'{index: idx, cont: c});
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (exp_indices.size() == 0) begin
            report_mismatch($sformatf("unexpected beat index=%0d cont=%0b",
                                      got.index, got.cont));
            return;
        end
        want = exp_indices.pop_front();
        n_results++;
        if (got.index !== want.index)
            report_mismatch($sformatf("index got %0d want %0d", got.index, want.index));
        if (got.cont !== want.cont)
            report_mismatch($sformatf("cont got %0b want %0b at index %0d",
                                      got.cont, want.cont, want.index));
    endtask

    // values are settled by the falling edge; acceptance happens at the next rising edge
    always @(negedge clk) begin
        if (rst_n) begin
            moved = 1'b0;
            if (in_valid && !in_stall) begin
                predict_index_beat(in_data);
                n_beats++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall) begin
                check_result(out_data);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_beat(input t_in_item it);
        bit taken;
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (exp_indices.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_mode(input logic [4:0] v);
        hold_until_drained();
        // a terminating advance leaves no beat behind, so give it time to settle
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        seq_mode = v;
        n_mode_writes++;
    endtask

    task automatic advance_to_idle(inout int done, input bit noisy);
        while (seq_running) begin
            if (noisy && $urandom_range(99) < 4)
                send_beat(mk_item(KIND_START, rand64(), rand64(), rand64()));
            if (noisy && $urandom_range(199) == 0)
                hold_until_drained();
            send_beat(mk_item(KIND_ADVANCE, rand64(), rand64(), rand64()));
            done++;
        end
    endtask

    task automatic run_fixed(input logic signed [63:0] s, input logic signed [63:0] st,
                             input logic signed [63:0] b);
        int done;
        done = 0;
        send_beat(mk_item(KIND_START, s, st, b));
        advance_to_idle(done, 1'b0);
    endtask

    task automatic pick_sequence(output logic signed [63:0] s, output logic signed [63:0] st,
                                 output logic signed [63:0] b);
        logic [4:0] eff;
        int n;
        int off;
        bit found;
        eff = seq_mode & (~seq_mode + 5'd1);
        found = 1'b0;
        for (int tries = 0; tries < 400 && !found; tries++) begin
            s = rand64();
            case ($urandom_range(3))
                0: s = IDX_MIN + 64'($urandom_range(500));
                1: s = IDX_MAX - 64'($urandom_range(500));
                default: ;
            endcase
            if ($urandom_range(4) == 0) begin
                st = rand64();
                b  = rand64();
            end else begin
                st = 64'($urandom_range(1000, 1));
                st = st <<< $urandom_range(52);
                if (eff == MODE_GT || eff == MODE_GE || (eff == MODE_NE && $urandom_range(1)))
                    st = -st;
                n = $urandom_range(12);
                b = s + st * 64'(n);
                if (eff != MODE_NE) begin
                    off = $urandom_range(2);
                    b = b + 64'(off) - 64'sd1;
                end
            end
            found = (seq_len(seq_mode, s, st, b) != 0);
        end
        if (!found) begin
            // first compare fails in every mode
            s  = '0;
            st = '0;
            b  = (eff == MODE_GE) ? 64'sd1 : ((eff == MODE_LE) ? -64'sd1 : 64'sd0);
        end
    endtask

    task automatic run_sequence(inout int done);
        logic signed [63:0] s, st, b;
        pick_sequence(s, st, b);
        send_beat(mk_item(KIND_START, s, st, b));
        done++;
        advance_to_idle(done, 1'b1);
    endtask

    task automatic test_idle_advance();
        send_beat(mk_item(KIND_ADVANCE, rand64(), rand64(), rand64()));
    endtask

    task automatic test_lt_at_max();
        send_beat(mk_item(KIND_START, IDX_MAX - 1, 64'sd1, IDX_MAX));
        send_beat(mk_item(KIND_START, IDX_MIN, IDX_MIN, IDX_MIN));
        send_beat(mk_item(KIND_ADVANCE, '0, '0, '0));
        hold_until_drained();
        send_beat(mk_item(KIND_ADVANCE, '1, '1, '1));
    endtask

    task automatic test_ne_wrap();
        set_mode(MODE_NE);
        run_fixed(IDX_MAX, 64'sd1, IDX_MIN + 1);
    endtask

    task automatic test_no_mode();
        set_mode(5'd0);
        run_fixed(IDX_MIN, IDX_MAX, IDX_MIN);
    endtask

    task automatic test_mode_priority();
        set_mode(MODE_LT | MODE_LE | MODE_GT | MODE_GE | MODE_NE);
        run_fixed(64'sd5, 64'sd1, 64'sd6);
        set_mode(MODE_LE | MODE_GT | MODE_GE | MODE_NE);
        run_fixed(-64'sd1, 64'sd1, 64'sd0);
        set_mode(MODE_GT | MODE_GE);
        run_fixed(64'sd2, -64'sd2, 64'sd0);
    endtask

    task automatic test_ge_countdown();
        set_mode(MODE_GE);
        run_fixed(64'sd0, -64'sd1, -64'sd1);
    endtask

    task automatic test_random(input int n_items, input int snd_pct, input int rcv_pct,
                               input logic [4:0] first_mode);
        int done;
        int k;
        logic [4:0] m;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        for (int chunk = 0; chunk < 4; chunk++) begin
            if (chunk == 0) begin
                m = first_mode;
            end else begin
                k = $urandom_range(5);
                m = (k == 5) ? 5'd0
                  : ((5'd1 << k) | ((5'($urandom_range(31)) >> (k + 1)) << (k + 1)));
            end
            set_mode(m);
            done = 0;
            while (done < n_items / 4) begin
                if ($urandom_range(99) < 8)
                    send_beat(mk_item(KIND_ADVANCE, rand64(), rand64(), rand64()));
                else
                    run_sequence(done);
            end
        end
    endtask

    initial begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        in_valid      <= 1'b0;
        in_data       <= '0;
        out_stall     <= 1'b0;
        snd_idle_pct  = 6;
        rcv_stall_pct = 74;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_advance();
        test_lt_at_max();
        test_ne_wrap();
        test_no_mode();
        test_mode_priority();
        test_ge_countdown();
        test_random(570, 6, 74, MODE_LT | MODE_LE | MODE_GT | MODE_GE | MODE_NE);
        test_random(570, 74, 6, 5'd0);
        test_random(570, 0, 0, MODE_NE);

        hold_until_drained();
        repeat (8) @(posedge clk);
        while (exp_indices.size() != 0)
            report_mismatch($sformatf("index %0d never came out",
                                      exp_indices.pop_front().index));

        $display("Run covered %0d input beats (%0d dropped), %0d index beats checked",
                 n_beats, n_dropped, n_results);
        $display("over %0d compare mode settings; %0d mismatches", n_mode_writes, n_errors);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lisg_pkg.sv
rtl/core/lisg_seq.sv
rtl/core/lisg_out_buf.sv
rtl/core/loop_index_stream_generator_unit.sv
verif/loop_index_stream_generator_unit_tb.sv
